>>> rtl/hiwm_pkg.sv
// ----------------------------------------------------------------------------
// hiwm_pkg
// Shared constants, register codes and stage payload types of the
// homography inverse warp mapper.
// ----------------------------------------------------------------------------
package hiwm_pkg;

    // image geometry
    localparam int SRC_WIDTH  = 1024;
    localparam int SRC_HEIGHT = 1024;
    localparam int OUT_HEIGHT = 480;

    // field widths
    localparam int COL_W   = 12;
    localparam int ROW_W   = 9;
    localparam int COORD_W = 10;
    localparam int ADDR_W  = 20;

    // coefficient format: Q16.32
    localparam int COEF_W = 48;
    localparam int FRAC_W = 32;

    // config port
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CX_COL = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CX_ROW = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CX_OFF = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CY_COL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CY_ROW = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CY_OFF = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_CW_COL = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_CW_ROW = 3'd7;

    // datapath widths
    localparam int PROD_W = COEF_W + COL_W + 1;   // coef times zero-extended col
    localparam int SUM_W  = PROD_W + 2;            // three-term sum
    localparam int MAG_W  = SUM_W - 1;             // magnitude of a sum

    // quotient bits: enough to hold the larger image dimension
    localparam int MAX_DIM = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int QB      = $clog2(MAX_DIM + 1);
    localparam int ADDR_FULL_W = 2 * QB + 1;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << FRAC_W);
    localparam logic signed [SUM_W-1:0]  W_ONE    = SUM_W'(64'd1 << FRAC_W);

    typedef struct packed {
        logic signed [COEF_W-1:0] cx_col;
        logic signed [COEF_W-1:0] cx_row;
        logic signed [COEF_W-1:0] cx_off;
        logic signed [COEF_W-1:0] cy_col;
        logic signed [COEF_W-1:0] cy_row;
        logic signed [COEF_W-1:0] cy_off;
        logic signed [COEF_W-1:0] cw_col;
        logic signed [COEF_W-1:0] cw_row;
    } coef_t;

    localparam coef_t COEF_RESET = '{
        cx_col: COEF_ONE,
        cx_row: '0,
        cx_off: '0,
        cy_col: '0,
        cy_row: COEF_ONE,
        cy_off: '0,
        cw_col: '0,
        cw_row: '0
    };

    // affine sums u, v, w
    typedef struct packed {
        logic                    row_ok;
        logic signed [SUM_W-1:0] u;
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] w;
    } sum_t;

    // long division state, one step per stage
    typedef struct packed {
        logic             row_ok;
        logic             wz;
        logic             ovf_x;
        logic             ovf_y;
        logic             sx;
        logic             sy;
        logic [MAG_W-1:0] mw;
        logic [MAG_W-1:0] px;
        logic [MAG_W-1:0] py;
        logic [QB-1:0]    dx;
        logic [QB-1:0]    dy;
    } div_t;

endpackage

>>> rtl/hiwm_affine.sv
// ----------------------------------------------------------------------------
// hiwm_affine
// Two stages: six coefficient products, then the u, v, w sums.
// ----------------------------------------------------------------------------
module hiwm_affine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hiwm_pkg::coef_t             coef,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [hiwm_pkg::COL_W-1:0]  col,
    input  logic [hiwm_pkg::ROW_W-1:0]  row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output hiwm_pkg::sum_t              out_data
);
    import hiwm_pkg::*;

    logic signed [COL_W:0]  col_s;
    logic signed [ROW_W:0]  row_s;

    logic signed [PROD_W-1:0] xc_next, xr_next, yc_next, yr_next, wc_next, wr_next;
    logic signed [PROD_W-1:0] xc_reg, xr_reg, yc_reg, yr_reg, wc_reg, wr_reg;
    logic                     row_ok_next, row_ok_reg;
    logic                     s1_valid_reg, s1_valid_next, s1_ready;

    sum_t sum_next, sum_reg;
    logic s2_valid_reg, s2_valid_next;

    assign col_s = signed'({1'b0, col});
    assign row_s = signed'({1'b0, row});

    // stage 1: products
    always_comb
    begin
        xc_next     = coef.cx_col * col_s;
        xr_next     = coef.cx_row * row_s;
        yc_next     = coef.cy_col * col_s;
        yr_next     = coef.cy_row * row_s;
        wc_next     = coef.cw_col * col_s;
        wr_next     = coef.cw_row * row_s;
        row_ok_next = int'(row) < OUT_HEIGHT;
    end

    assign s1_ready      = ~s2_valid_reg | out_ready;
    assign in_ready      = ~s1_valid_reg | s1_ready;
    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;

    // stage 2: sums
    always_comb
    begin
        sum_next.row_ok = row_ok_reg;
        sum_next.u      = SUM_W'(xc_reg) + SUM_W'(xr_reg) + SUM_W'(coef.cx_off);
        sum_next.v      = SUM_W'(yc_reg) + SUM_W'(yr_reg) + SUM_W'(coef.cy_off);
        sum_next.w      = SUM_W'(wc_reg) + SUM_W'(wr_reg) + W_ONE;
    end

    assign s2_valid_next = s1_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            xc_reg     <= xc_next;
            xr_reg     <= xr_next;
            yc_reg     <= yc_next;
            yr_reg     <= yr_next;
            wc_reg     <= wc_next;
            wr_reg     <= wr_next;
            row_ok_reg <= row_ok_next;
        end
        if (s1_valid_reg && s1_ready)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = sum_reg;

endmodule

>>> rtl/hiwm_prep.sv
// ----------------------------------------------------------------------------
// hiwm_prep
// Two stages: magnitudes and quotient signs, then divider setup with the
// quotient overflow check.
// ----------------------------------------------------------------------------
module hiwm_prep (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hiwm_pkg::sum_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hiwm_pkg::div_t out_data
);
    import hiwm_pkg::*;

    logic [MAG_W-1:0] mu_next, mv_next, mw_next;
    logic [MAG_W-1:0] mu_reg, mv_reg, mw_reg;
    logic             sx_next, sy_next, wz_next, row_ok_next;
    logic             sx_reg, sy_reg, wz_reg, row_ok_reg;
    logic             s1_valid_reg, s1_valid_next, s1_ready;

    div_t div_next, div_reg;
    logic s2_valid_reg, s2_valid_next;

    // stage 1: absolute values
    always_comb
    begin
        mu_next     = in_data.u[SUM_W-1] ? MAG_W'(-in_data.u) : MAG_W'(in_data.u);
        mv_next     = in_data.v[SUM_W-1] ? MAG_W'(-in_data.v) : MAG_W'(in_data.v);
        mw_next     = in_data.w[SUM_W-1] ? MAG_W'(-in_data.w) : MAG_W'(in_data.w);
        sx_next     = in_data.u[SUM_W-1] ^ in_data.w[SUM_W-1];
        sy_next     = in_data.v[SUM_W-1] ^ in_data.w[SUM_W-1];
        wz_next     = (in_data.w == '0);
        row_ok_next = in_data.row_ok;
    end

    assign s1_ready      = ~s2_valid_reg | out_ready;
    assign in_ready      = ~s1_valid_reg | s1_ready;
    assign s1_valid_next = in_ready ? in_valid : s1_valid_reg;

    // stage 2: high part starts the partial remainder, low QB bits shift in
    always_comb
    begin
        div_next.row_ok = row_ok_reg;
        div_next.wz     = wz_reg;
        div_next.sx     = sx_reg;
        div_next.sy     = sy_reg;
        div_next.mw     = mw_reg;
        div_next.px     = mu_reg >> QB;
        div_next.py     = mv_reg >> QB;
        div_next.dx     = mu_reg[QB-1:0];
        div_next.dy     = mv_reg[QB-1:0];
        // quotient needs more than QB bits
        div_next.ovf_x  = (mu_reg >> QB) >= mw_reg;
        div_next.ovf_y  = (mv_reg >> QB) >= mw_reg;
    end

    assign s2_valid_next = s1_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mu_reg     <= mu_next;
            mv_reg     <= mv_next;
            mw_reg     <= mw_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            wz_reg     <= wz_next;
            row_ok_reg <= row_ok_next;
        end
        if (s1_valid_reg && s1_ready)
        begin
            div_reg <= div_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_data  = div_reg;

endmodule

>>> rtl/hiwm_div_step.sv
// ----------------------------------------------------------------------------
// hiwm_div_step
// One restoring long-division step for x and y, one register stage.
// ----------------------------------------------------------------------------
module hiwm_div_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hiwm_pkg::div_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output hiwm_pkg::div_t out_data
);
    import hiwm_pkg::*;

    logic [MAG_W:0] tx, ty, dfx, dfy;
    logic           gex, gey;
    div_t           data_next, data_reg;
    logic           valid_reg, valid_next;

    always_comb
    begin
        tx  = {in_data.px, in_data.dx[QB-1]};
        ty  = {in_data.py, in_data.dy[QB-1]};
        gex = tx >= {1'b0, in_data.mw};
        gey = ty >= {1'b0, in_data.mw};
        dfx = tx - {1'b0, in_data.mw};
        dfy = ty - {1'b0, in_data.mw};

        data_next    = in_data;
        data_next.px = gex ? dfx[MAG_W-1:0] : tx[MAG_W-1:0];
        data_next.py = gey ? dfy[MAG_W-1:0] : ty[MAG_W-1:0];
        // dividend bits leave at the top, quotient bits enter at the bottom
        data_next.dx = QB'({in_data.dx, gex});
        data_next.dy = QB'({in_data.dy, gey});
    end

    assign in_ready   = ~valid_reg | out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/hiwm_bound.sv
// ----------------------------------------------------------------------------
// hiwm_bound
// Bounds check, linear address and the output register.
// ----------------------------------------------------------------------------
module hiwm_bound (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hiwm_pkg::div_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    output logic [hiwm_pkg::COORD_W-1:0]  src_x,
    output logic [hiwm_pkg::COORD_W-1:0]  src_y,
    output logic [hiwm_pkg::ADDR_W-1:0]   src_addr
);
    import hiwm_pkg::*;

    logic                   x_in, y_in;
    logic [ADDR_FULL_W-1:0] addr_full;

    logic                inside_next, inside_reg;
    logic [COORD_W-1:0]  x_next, x_reg, y_next, y_reg;
    logic [ADDR_W-1:0]   addr_next, addr_reg;
    logic                valid_reg, valid_next;

    always_comb
    begin
        // truncation toward zero: a negative quotient is fine only if it is zero
        x_in = ~in_data.ovf_x && (in_data.dx < QB'(SRC_WIDTH))
               && (~in_data.sx || (in_data.dx == '0));
        y_in = ~in_data.ovf_y && (in_data.dy < QB'(SRC_HEIGHT))
               && (~in_data.sy || (in_data.dy == '0));
        inside_next = in_data.row_ok && ~in_data.wz && x_in && y_in;

        addr_full = ADDR_FULL_W'(in_data.dy) * ADDR_FULL_W'(SRC_WIDTH)
                  + ADDR_FULL_W'(in_data.dx);

        x_next    = inside_next ? COORD_W'(in_data.dx) : '0;
        y_next    = inside_next ? COORD_W'(in_data.dy) : '0;
        addr_next = inside_next ? ADDR_W'(addr_full)   : '0;
    end

    assign in_ready   = ~valid_reg | out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            inside_reg <= inside_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            addr_reg   <= addr_next;
        end
    end

    assign out_valid  = valid_reg;
    assign inside_res = inside_reg;
    assign src_x      = x_reg;
    assign src_y      = y_reg;
    assign src_addr   = addr_reg;

endmodule

>>> rtl/homography_inverse_warp_mapper.sv
// ----------------------------------------------------------------------------
// homography_inverse_warp_mapper
// Pipeline: QB + 5 register stages, most of them in the chain of one-bit
// restoring division stages.
// Throughput: one item per cycle while out_ready stays high; each stage stalls on its own, so
// bubbles close up and input is taken while a finished result waits.
// Reset: coefficients load identity (x = col, y = row), pipeline empties.
// ----------------------------------------------------------------------------
module homography_inverse_warp_mapper (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [hiwm_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [hiwm_pkg::COEF_W-1:0]     cfg_data,

    // input items: one output pixel position each
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hiwm_pkg::COL_W-1:0]      out_col,
    input  logic [hiwm_pkg::ROW_W-1:0]      out_row,

    // result items: mapped source pixel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            inside_res,
    output logic [hiwm_pkg::COORD_W-1:0]    src_x,
    output logic [hiwm_pkg::COORD_W-1:0]    src_y,
    output logic [hiwm_pkg::ADDR_W-1:0]     src_addr
);
    import hiwm_pkg::*;

    // ------------------------------------------------------------------
    // Coefficient registers. These must be written only while the pipe
    // is idle, which the block itself does not enforce; so every stage may read them directly.
    // ------------------------------------------------------------------
    coef_t coef_reg, coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CX_COL: coef_next.cx_col = cfg_data;
                REG_CX_ROW: coef_next.cx_row = cfg_data;
                REG_CX_OFF: coef_next.cx_off = cfg_data;
                REG_CY_COL: coef_next.cy_col = cfg_data;
                REG_CY_ROW: coef_next.cy_row = cfg_data;
                REG_CY_OFF: coef_next.cy_off = cfg_data;
                REG_CW_COL: coef_next.cw_col = cfg_data;
                REG_CW_ROW: coef_next.cw_row = cfg_data;
                default:    coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= COEF_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 1-2: u, v, w in Q31.32. Products are exact, the row range
    // check rides along as row_ok.
    // ------------------------------------------------------------------
    sum_t aff_data;
    logic aff_valid, aff_ready;

    hiwm_affine u_affine (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .col       (out_col),
        .row       (out_row),
        .out_valid (aff_valid),
        .out_ready (aff_ready),
        .out_data  (aff_data)
    );

    // ------------------------------------------------------------------
    // Stages 3-4: sign/magnitude split. u/w truncated toward zero equals
    // sign * floor(|u|/|w|), so the divider works on magnitudes only. A
    // quotient wider than QB bits is out of the image anyway and is only
    // flagged.
    // ------------------------------------------------------------------
    div_t div_data  [QB+1];
    logic div_valid [QB+1];
    logic div_ready [QB+1];

    hiwm_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (aff_valid),
        .in_ready  (aff_ready),
        .in_data   (aff_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // ------------------------------------------------------------------
    // QB division stages, one quotient bit each, x and y side by side
    // sharing the |w| divisor.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        hiwm_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_data   (div_data[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_data  (div_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Last stage: zero denominator, row range and image bounds; outside
    // items report all-zero fields.
    // ------------------------------------------------------------------
    hiwm_bound u_bound (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid[QB]),
        .in_ready   (div_ready[QB]),
        .in_data    (div_data[QB]),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .src_x      (src_x),
        .src_y      (src_y),
        .src_addr   (src_addr)
    );

endmodule
